/* design/mme_pkg.sv */
// Shared widths, codes and payload types for the matrix multiply engine.
package mme_pkg;

  // Default for the largest matrix dimension held in the stores
  localparam int MAX_DIM_DEF = 64;

  // Field widths fixed by the interface
  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 6;
  localparam int ELEM_W  = 64;
  localparam int STAT_W  = 2;
  localparam int DIM_W   = 7;
  localparam int CIDX_W  = 2;
  // Width for comparing a dimension against the largest one (up to 255)
  localparam int LIM_W   = 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WR_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_P = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOB      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CIDX_W-1:0] REG_B_COLS = 2'd3;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [DIM_W-1:0]  dim_t;

endpackage

/* design/mme_if.sv */
// Valid/ready channel interfaces for the matrix multiply engine.
interface mme_in_if;
  logic                        valid;
  logic                        ready;
  logic [mme_pkg::FUNC_W-1:0]  func;
  logic [mme_pkg::IDX_W-1:0]   row_index;
  logic [mme_pkg::IDX_W-1:0]   col_index;
  mme_pkg::elem_t              elem_value;

  modport source (output valid, func, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, func, row_index, col_index, elem_value, output ready);
endinterface

interface mme_out_if;
  logic                        valid;
  logic                        ready;
  mme_pkg::elem_t              product_value;
  logic [mme_pkg::STAT_W-1:0]  status;

  modport source (output valid, product_value, status, input ready);
  modport sink   (input valid, product_value, status, output ready);
endinterface

interface mme_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mme_pkg::CIDX_W-1:0]  index;
  mme_pkg::dim_t               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/matrix_multiply_engine.sv */
// Top level: matrix stores, dot-product sequencer and result register.
//
// Two stores of MAX_DIM*MAX_DIM 64-bit words hold matrices A and B. A write beat
// stores one element; its result beat passes the finish state into the output
// register. A product read walks the inner dimension min(a_cols, MAX_DIM)
// one multiply-accumulate per cycle, limited by the single read port of each
// store. Each term goes through the registered store read and the split 64-bit
// multiply into the accumulator; the sum then goes to the output register. One item
// is in work at a time; a new item is taken while the previous result waits on
// the output. Products wrap modulo 2^64. Stores are not cleared by reset: reading
// a product from elements never written gives an undefined value.
module matrix_multiply_engine #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mme_in_if.sink     in_bus,
  mme_out_if.source  out_bus,
  mme_cfg_if.sink    cfg_bus
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW     = $clog2(MAX_DIM + 1);
  localparam logic [mme_pkg::LIM_W-1:0] MAX_L = mme_pkg::LIM_W'(MAX_DIM);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  function automatic logic [mme_pkg::LIM_W-1:0] clamp_dim(input mme_pkg::dim_t d);
    logic [mme_pkg::LIM_W-1:0] dx;
    dx = mme_pkg::LIM_W'(d);
    return (dx > MAX_L) ? MAX_L : dx;
  endfunction

  // Storage
  mme_pkg::elem_t left_mem  [DEPTH];
  mme_pkg::elem_t right_mem [DEPTH];

  // Configuration
  mme_pkg::dim_t a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  // Sequencer and datapath registers
  logic [1:0]                   state_r, state_nxt;
  logic [KW-1:0]                k_r, k_nxt;
  logic [KW-1:0]                inner_r, inner_nxt;
  logic [mme_pkg::IDX_W-1:0]    row_r, col_r;
  mme_pkg::elem_t               acc_r, acc_nxt;
  logic [mme_pkg::STAT_W-1:0]   status_r, status_nxt;
  logic                         rd_v_r, prod_v_r;
  mme_pkg::elem_t               left_q_r, right_q_r;
  mme_pkg::elem_t               pll_r;
  logic [31:0]                  pcross_r;
  logic                         out_valid_r;
  mme_pkg::elem_t               out_value_r;
  logic [mme_pkg::STAT_W-1:0]   out_status_r;

  logic                         in_acc, issue, out_free, pipe_empty;
  logic                         wr_a_en, wr_b_en;
  logic [ADDR_W-1:0]            wr_addr, rd_addr_l, rd_addr_r;
  logic [mme_pkg::LIM_W-1:0]    in_row_l, in_col_l;

  assign in_bus.ready      = (state_r == ST_IDLE);
  assign in_acc            = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready     = 1'b1;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.product_value = out_value_r;
  assign out_bus.status    = out_status_r;
  assign out_free          = !out_valid_r || out_bus.ready;
  assign issue             = (state_r == ST_MAC) && (k_r != inner_r);
  assign pipe_empty        = !rd_v_r && !prod_v_r;

  assign in_row_l = mme_pkg::LIM_W'(in_bus.row_index);
  assign in_col_l = mme_pkg::LIM_W'(in_bus.col_index);

  // Addresses: row-major, MAX_DIM words per row
  assign wr_addr   = ADDR_W'(ADDR_W'(in_bus.row_index) * ADDR_W'(MAX_DIM)
                             + ADDR_W'(in_bus.col_index));
  assign rd_addr_l = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r));
  assign rd_addr_r = ADDR_W'(ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(col_r));

  // Decode the accepted beat (bounds, status and store enables) and step the sequencer
  always_comb begin
    wr_a_en    = 1'b0;
    wr_b_en    = 1'b0;
    state_nxt  = state_r;
    k_nxt      = k_r;
    inner_nxt  = inner_r;
    status_nxt = status_r;
    acc_nxt    = prod_v_r ? acc_r + pll_r + {pcross_r, 32'd0} : acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          acc_nxt    = '0;
          status_nxt = mme_pkg::STAT_OK;
          k_nxt      = '0;
          inner_nxt  = KW'(clamp_dim(a_cols_r));
          state_nxt  = ST_FIN;
          unique case (in_bus.func)
            mme_pkg::FUNC_WR_A: begin
              if (in_row_l < clamp_dim(a_rows_r) && in_col_l < clamp_dim(a_cols_r))
                wr_a_en = 1'b1;
              else
                status_nxt = mme_pkg::STAT_OOB;
            end
            mme_pkg::FUNC_WR_B: begin
              if (in_row_l < clamp_dim(b_rows_r) && in_col_l < clamp_dim(b_cols_r))
                wr_b_en = 1'b1;
              else
                status_nxt = mme_pkg::STAT_OOB;
            end
            mme_pkg::FUNC_RD_P: begin
              if (a_cols_r != b_rows_r)
                status_nxt = mme_pkg::STAT_MISMATCH;
              else if (in_row_l >= clamp_dim(a_rows_r) || in_col_l >= clamp_dim(b_cols_r))
                status_nxt = mme_pkg::STAT_OOB;
              else
                state_nxt = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        if (issue)
          k_nxt = k_r + KW'(1);
        else if (pipe_empty)
          state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free)
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      inner_r     <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= mme_pkg::STAT_OK;
      a_rows_r    <= mme_pkg::DIM_W'(1);
      a_cols_r    <= mme_pkg::DIM_W'(1);
      b_rows_r    <= mme_pkg::DIM_W'(1);
      b_cols_r    <= mme_pkg::DIM_W'(1);
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      inner_r  <= inner_nxt;
      status_r <= status_nxt;
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      // Load the result when the output slot is free, drop it when taken
      if (state_r == ST_FIN && out_free)
        out_valid_r <= 1'b1;
      else if (out_bus.ready)
        out_valid_r <= 1'b0;
      // Register writes
      if (cfg_bus.valid && cfg_bus.ready) begin
        unique case (cfg_bus.index)
          mme_pkg::REG_A_ROWS: a_rows_r <= cfg_bus.data;
          mme_pkg::REG_A_COLS: a_cols_r <= cfg_bus.data;
          mme_pkg::REG_B_ROWS: b_rows_r <= cfg_bus.data;
          mme_pkg::REG_B_COLS: b_cols_r <= cfg_bus.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (in_acc) begin
      row_r <= in_bus.row_index;
      col_r <= in_bus.col_index;
    end
    // Split 64x64 low product into three 32-bit multiplies
    pll_r    <= {32'd0, left_q_r[31:0]} * {32'd0, right_q_r[31:0]};
    pcross_r <= 32'(left_q_r[31:0] * right_q_r[63:32])
              + 32'(left_q_r[63:32] * right_q_r[31:0]);
    if (state_r == ST_FIN && out_free) begin
      out_value_r  <= acc_r;
      out_status_r <= status_r;
    end
  end

  // Store A: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_a_en)
      left_mem[wr_addr] <= in_bus.elem_value;
    if (issue)
      left_q_r <= left_mem[rd_addr_l];
  end

  // Store B: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_b_en)
      right_mem[wr_addr] <= in_bus.elem_value;
    if (issue)
      right_q_r <= right_mem[rd_addr_r];
  end

  // The multiply pipeline is empty whenever the sequencer is idle
  a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_v_r && !prod_v_r))
    else $error("multiply pipeline busy while idle");

  // The inner counter never runs past the inner dimension
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (k_r <= inner_r))
    else $error("inner counter overran");

  // A result beat appears only out of the finish state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result beat without finished item");

endmodule

/* test/matrix_multiply_engine_tb.sv */
// Self-checking testbench for the matrix multiply engine: element writes, product reads, checks.
module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int MAX_DIM        = MAX_DIM_DEF;
  localparam int STORE_WORDS    = MAX_DIM * MAX_DIM;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;
  localparam int DRAIN_CYCLES   = MAX_DIM + 16;
  localparam int TIMEOUT_CYCLES = 400000;

  // Unused operation code: the block answers with an empty ok beat
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    elem_t                value;
    logic [STAT_W-1:0]    status;
  } product_beat_t;

  // Matrix stores, dimensions and the queue of product beats still owed
  class product_scoreboard;
    dim_t          a_rows, a_cols, b_rows, b_cols;
    elem_t         left_mem[STORE_WORDS];
    elem_t         right_mem[STORE_WORDS];
    bit            left_set[STORE_WORDS];
    bit            right_set[STORE_WORDS];
    product_beat_t expected_q[$];
    int unsigned   fail_count;

    function new();
      a_rows = 1;
      a_cols = 1;
      b_rows = 1;
      b_cols = 1;
      fail_count = 0;
    endfunction

    function void set_dim(logic [CIDX_W-1:0] idx, dim_t data);
      case (idx)
        REG_A_ROWS: a_rows = data;
        REG_A_COLS: a_cols = data;
        REG_B_ROWS: b_rows = data;
        REG_B_COLS: b_cols = data;
        default: ;
      endcase
    endfunction

    // Saturate a dimension at the store size
    function int usable(dim_t d);
      return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // True when a read at (r, c) walks the stores
    function bit product_in_range(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
      return (a_cols == b_rows) && (int'(r) < usable(a_rows)) && (int'(c) < usable(b_cols));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Predict the beat caused by one accepted input beat
    function void note_input(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] r,
                             logic [IDX_W-1:0] c, elem_t v);
      product_beat_t beat;
      elem_t         acc;
      int            addr;
      beat.value  = '0;
      beat.status = STAT_OK;
      addr = int'(r) * MAX_DIM + int'(c);
      case (func)
        FUNC_WR_A: begin
          if (int'(r) < usable(a_rows) && int'(c) < usable(a_cols)) begin
            left_mem[addr] = v;
            left_set[addr] = 1'b1;
          end else begin
            beat.status = STAT_OOB;
          end
        end
        FUNC_WR_B: begin
          if (int'(r) < usable(b_rows) && int'(c) < usable(b_cols)) begin
            right_mem[addr] = v;
            right_set[addr] = 1'b1;
          end else begin
            beat.status = STAT_OOB;
          end
        end
        FUNC_RD_P: begin
          if (a_cols != b_rows) begin
            beat.status = STAT_MISMATCH;
          end else if (!product_in_range(r, c)) begin
            beat.status = STAT_OOB;
          end else begin
            acc = '0;
            for (int k = 0; k < usable(a_cols); k++) begin
              acc = acc + left_mem[int'(r) * MAX_DIM + k] * right_mem[k * MAX_DIM + int'(c)];
            end
            beat.value = acc;
          end
        end
        default: ;
      endcase
      expected_q.push_back(beat);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(elem_t value, logic [STAT_W-1:0] status);
      product_beat_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: product_value %h status %0d", value, status);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) begin
        $error("product_value mismatch: expected %h, actual %h", want.value, value);
        fail_count++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mme_in_if  in_bus();
  mme_out_if out_bus();
  mme_cfg_if cfg_bus();

  matrix_multiply_engine i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  product_scoreboard sb;
  int unsigned       feed_gap_pct;
  int unsigned       drain_stall_pct;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_bus.ready <= (drain_stall_pct == 0) || ($urandom_range(99) >= drain_stall_pct);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check_result(out_bus.product_value, out_bus.status);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("matrix_multiply_engine_tb failed");
    $finish;
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return elem_t'($urandom_range(15));
      3: return {1'b1, {(ELEM_W - 1){1'b0}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      1: begin feed_gap_pct = 65; drain_stall_pct = 0; end
      2: begin feed_gap_pct = 0; drain_stall_pct = 65; end
      3: begin feed_gap_pct = 36; drain_stall_pct = 36; end
      default: begin feed_gap_pct = 0; drain_stall_pct = 0; end
    endcase
  endtask

  // Drive one input beat; called and returning at a falling edge, valid left high
  task automatic send_item(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] r,
                           logic [IDX_W-1:0] c, elem_t v);
    while (feed_gap_pct != 0 && $urandom_range(99) < feed_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= func;
    in_bus.row_index  <= r;
    in_bus.col_index  <= c;
    in_bus.elem_value <= v;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    sb.note_input(func, r, c, v);
    @(negedge clk);
  endtask

  // Fill any element the read would touch that was never written, then read
  task automatic read_product(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    if (sb.product_in_range(r, c)) begin
      for (int k = 0; k < sb.usable(sb.a_cols); k++) begin
        if (!sb.left_set[int'(r) * MAX_DIM + k])
          send_item(FUNC_WR_A, r, IDX_W'(k), rand_elem());
        if (!sb.right_set[k * MAX_DIM + int'(c)])
          send_item(FUNC_WR_B, IDX_W'(k), c, rand_elem());
      end
    end
    send_item(FUNC_RD_P, r, c, rand_elem());
  endtask

  // Write all four dimension registers, valid held high across the beats
  task automatic program_dims(dim_t ar, dim_t ac, dim_t br, dim_t bc);
    logic [CIDX_W-1:0] idx_list[4];
    dim_t              val_list[4];
    idx_list = '{REG_A_ROWS, REG_A_COLS, REG_B_ROWS, REG_B_COLS};
    val_list = '{ar, ac, br, bc};
    for (int i = 0; i < 4; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx_list[i];
      cfg_bus.data  <= val_list[i];
      @(posedge clk);
      while (cfg_bus.ready !== 1'b1) @(posedge clk);
      sb.set_dim(idx_list[i], val_list[i]);
      @(negedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop valid, wait out every owed beat, then let the block settle
  task automatic finish_phase();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_items(int unsigned count);
    int unsigned       done;
    int unsigned       roll;
    int                rows;
    int                cols;
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        // element write, mostly in bounds
        rows = (roll < 40) ? sb.usable(sb.a_rows) : sb.usable(sb.b_rows);
        cols = (roll < 40) ? sb.usable(sb.a_cols) : sb.usable(sb.b_cols);
        if (rows > 0 && cols > 0 && $urandom_range(9) != 0) begin
          r = IDX_W'($urandom_range(rows - 1));
          c = IDX_W'($urandom_range(cols - 1));
        end else begin
          r = IDX_W'($urandom_range(IDX_MAX));
          c = IDX_W'($urandom_range(IDX_MAX));
        end
        send_item((roll < 40) ? FUNC_WR_A : FUNC_WR_B, r, c, rand_elem());
        done++;
      end else if (roll < 93) begin
        // product read, mostly in bounds
        rows = sb.usable(sb.a_rows);
        cols = sb.usable(sb.b_cols);
        if (rows > 0 && cols > 0 && $urandom_range(5) != 0) begin
          r = IDX_W'($urandom_range(rows - 1));
          c = IDX_W'($urandom_range(cols - 1));
        end else begin
          r = IDX_W'($urandom_range(IDX_MAX));
          c = IDX_W'($urandom_range(IDX_MAX));
        end
        read_product(r, c);
        done++;
      end else begin
        send_item(FUNC_NOP, IDX_W'($urandom_range(IDX_MAX)),
                  IDX_W'($urandom_range(IDX_MAX)), rand_elem());
      end
    end
  endtask

  task automatic run_phase(dim_t ar, dim_t ac, dim_t br, dim_t bc, int mode,
                           int unsigned count);
    set_idling(mode);
    program_dims(ar, ac, br, bc);
    random_items(count);
    finish_phase();
  endtask

  initial begin
    sb = new();
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = FUNC_WR_A;
    in_bus.row_index   = '0;
    in_bus.col_index   = '0;
    in_bus.elem_value  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_A_ROWS;
    cfg_bus.data       = '0;
    out_bus.ready      = 1'b0;
    set_idling(0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset dimensions: wraparound, bounds, unused code
    send_item(FUNC_WR_A, 0, 0, '1);
    send_item(FUNC_WR_B, 0, 0, '1);
    send_item(FUNC_RD_P, 0, 0, '0);
    send_item(FUNC_WR_A, 0, 0, {1'b1, {(ELEM_W - 1){1'b0}}});
    send_item(FUNC_WR_B, 0, 0, elem_t'(2));
    send_item(FUNC_RD_P, 0, 0, '1);
    send_item(FUNC_WR_A, 1, 0, '1);
    send_item(FUNC_WR_A, 0, IDX_MAX, '1);
    send_item(FUNC_WR_B, IDX_MAX, IDX_MAX, '1);
    send_item(FUNC_RD_P, 1, 0, '0);
    send_item(FUNC_RD_P, 0, IDX_MAX, '0);
    send_item(FUNC_RD_P, IDX_MAX, IDX_MAX, '0);
    send_item(FUNC_NOP, IDX_MAX, IDX_MAX, '1);
    send_item(FUNC_RD_P, 0, 0, '0);
    finish_phase();

    // Inner dimensions differ: mismatch wins over the bounds check
    program_dims(1, 1, 2, 1);
    send_item(FUNC_RD_P, 0, 0, '0);
    send_item(FUNC_RD_P, IDX_MAX, IDX_MAX, '0);
    send_item(FUNC_WR_B, 1, 0, elem_t'(5));
    send_item(FUNC_WR_B, 2, 0, elem_t'(5));
    finish_phase();

    run_phase(4, 4, 4, 4, 1, 80);
    run_phase(3, 5, 5, 2, 2, 60);
    run_phase(2, 3, 4, 3, 3, 30);
    run_phase(0, 0, 0, 0, 0, 20);

    // Oversized registers saturate: full-length dot product at the far corner
    set_idling(1);
    program_dims(7'd127, 7'd127, 7'd127, 7'd127);
    read_product(IDX_MAX, IDX_MAX);
    finish_phase();

    // Exact largest dimensions: reuse the far-corner operands, then change one
    set_idling(2);
    program_dims(7'd64, 7'd64, 7'd64, 7'd64);
    read_product(IDX_MAX, IDX_MAX);
    send_item(FUNC_WR_A, IDX_MAX, 5, rand_elem());
    read_product(IDX_MAX, IDX_MAX);
    finish_phase();

    run_phase(65, 8, 8, 100, 3, 30);
    run_phase(7, 1, 1, 7, 0, 40);

    if (sb.fail_count == 0) begin
      $display("matrix_multiply_engine_tb passed");
    end else begin
      $display("matrix_multiply_engine_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mme_pkg.sv
design/mme_if.sv
design/matrix_multiply_engine.sv
test/matrix_multiply_engine_tb.sv
